/* hw/rtl/msq_pkg.sv */
// shared types and constants for the motor play-pattern sequencer
`default_nettype none

package msq_pkg;

    // operation codes carried in tuser
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    // play modes
    localparam logic [1:0] MODE_CALM   = 2'd0;
    localparam logic [1:0] MODE_BUILD  = 2'd1;
    localparam logic [1:0] MODE_FRENZY = 2'd2;
    localparam logic [1:0] MODE_STOP   = 2'd3;

    // motor directions
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // cycle lengths in ms
    localparam logic [31:0] CHILL_CYCLE_MS  = 32'd8000;
    localparam logic [31:0] WARMUP_CYCLE_MS = 32'd3000;
    localparam logic [31:0] CRAZY_CYCLE_MS  = 32'd1000;

    // chill phase boundaries
    localparam logic [31:0] CHILL_FWD_END_MS = 32'd2000;
    localparam logic [31:0] CHILL_REV_BEG_MS = 32'd3000;
    localparam logic [31:0] CHILL_REV_END_MS = 32'd5000;

    // warmup phase boundaries
    localparam logic [31:0] WARMUP_RUN_END_MS   = 32'd1500;
    localparam logic [31:0] WARMUP_BURST_END_MS = 32'd2000;

    // crazy phase boundaries
    localparam logic [31:0] CRAZY_SHORT_END_MS = 32'd500;
    localparam logic [31:0] CRAZY_LONG_END_MS  = 32'd700;

    // behaviour state kept between beats
    typedef struct packed {
        logic [31:0] cycle_start_ms;
        logic [2:0]  pattern_number;
    } msq_state_t;

    // motor command for one beat
    typedef struct packed {
        logic [1:0] direction;
        logic [7:0] duty;
    } msq_result_t;

endpackage

`default_nettype wire

/* hw/rtl/msq_tick.sv */
// per-beat pattern logic: cycle bookkeeping, next state and motor command
`default_nettype none

module msq_tick #(
    parameter int FULL_DUTY = 255
) (
    input  wire logic                operation,
    input  wire logic [1:0]          play_mode,
    input  wire logic [31:0]         now_ms,
    input  wire logic [2:0]          random_pick,
    input  wire msq_pkg::msq_state_t state_cur,
    output msq_pkg::msq_state_t      state_next,
    output msq_pkg::msq_result_t     result,
    output logic                     has_result
);

    localparam logic [7:0] DUTY_FULL = 8'(FULL_DUTY);
    localparam logic [7:0] DUTY_50   = 8'(FULL_DUTY * 50 / 100);
    localparam logic [7:0] DUTY_60   = 8'(FULL_DUTY * 60 / 100);
    localparam logic [7:0] DUTY_80   = 8'(FULL_DUTY * 80 / 100);
    localparam logic [7:0] DUTY_90   = 8'(FULL_DUTY * 90 / 100);

    logic [31:0] cycle_len;
    logic [2:0]  pick_m;
    logic [31:0] start_eff;
    logic [2:0]  pat_eff;
    logic [31:0] elapsed;
    logic [1:0]  dir_run;
    logic        flip;

    // cycle length and pick mask for the current mode
    always_comb begin
        case (play_mode)
            msq_pkg::MODE_CALM: begin
                cycle_len = msq_pkg::CHILL_CYCLE_MS;
                pick_m    = 3'd0;
            end
            msq_pkg::MODE_BUILD: begin
                cycle_len = msq_pkg::WARMUP_CYCLE_MS;
                pick_m    = {1'b0, random_pick[1:0]};
            end
            default: begin
                cycle_len = msq_pkg::CRAZY_CYCLE_MS;
                pick_m    = random_pick;
            end
        endcase
    end

    // start a cycle if not started, restart once elapsed passes the length
    always_comb begin
        start_eff = state_cur.cycle_start_ms;
        pat_eff   = state_cur.pattern_number;
        if (state_cur.cycle_start_ms == 32'd0) begin
            start_eff = now_ms;
            pat_eff   = pick_m;
        end
        elapsed = now_ms - start_eff;
        if (elapsed > cycle_len) begin
            start_eff = now_ms;
            pat_eff   = pick_m;
            elapsed   = 32'd0;
        end
    end

    // state clears on reset beats and moves on update beats only in a running mode
    always_comb begin
        if (operation == msq_pkg::OP_RESET) begin
            state_next = '0;
        end else if (play_mode == msq_pkg::MODE_STOP) begin
            state_next = state_cur;
        end else begin
            state_next.cycle_start_ms = start_eff;
            state_next.pattern_number = pat_eff;
        end
    end

    assign has_result = (operation == msq_pkg::OP_UPDATE);

    // odd 200 ms slot within the crazy cycle
    assign flip = elapsed inside {[32'd200:32'd399], [32'd600:32'd799], [32'd1000:32'd1199]};

    // motor command per mode
    always_comb begin
        result.direction = msq_pkg::DIR_STOP;
        result.duty      = 8'd0;
        dir_run          = msq_pkg::DIR_FWD;
        case (play_mode)
            msq_pkg::MODE_CALM: begin
                if (elapsed < msq_pkg::CHILL_FWD_END_MS) begin
                    result.direction = msq_pkg::DIR_FWD;
                    result.duty      = DUTY_60;
                end else if (elapsed >= msq_pkg::CHILL_REV_BEG_MS &&
                             elapsed < msq_pkg::CHILL_REV_END_MS) begin
                    result.direction = msq_pkg::DIR_REV;
                    result.duty      = DUTY_60;
                end
            end
            msq_pkg::MODE_BUILD: begin
                dir_run = (pat_eff >= 3'd2) ? msq_pkg::DIR_REV : msq_pkg::DIR_FWD;
                if (elapsed < msq_pkg::WARMUP_RUN_END_MS) begin
                    result.direction = dir_run;
                    result.duty      = DUTY_50;
                end else if (elapsed < msq_pkg::WARMUP_BURST_END_MS &&
                             (pat_eff == 3'd1 || pat_eff == 3'd3)) begin
                    result.direction = dir_run;
                    result.duty      = DUTY_80;
                end
            end
            msq_pkg::MODE_FRENZY: begin
                dir_run = pat_eff[2] ? msq_pkg::DIR_REV : msq_pkg::DIR_FWD;
                case (pat_eff[1:0])
                    2'd0: begin
                        result.direction = dir_run;
                        result.duty      = DUTY_FULL;
                    end
                    2'd1: begin
                        if (elapsed < msq_pkg::CRAZY_SHORT_END_MS) begin
                            result.direction = dir_run;
                            result.duty      = DUTY_90;
                        end
                    end
                    2'd2: begin
                        if (elapsed < msq_pkg::CRAZY_LONG_END_MS) begin
                            result.direction = dir_run;
                            result.duty      = DUTY_60;
                        end
                    end
                    default: begin
                        result.direction = (pat_eff[2] != flip) ? msq_pkg::DIR_REV
                                                                : msq_pkg::DIR_FWD;
                        result.duty      = DUTY_FULL;
                    end
                endcase
            end
            default: begin
                result.direction = msq_pkg::DIR_STOP;
                result.duty      = 8'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/motor_play_pattern_sequencer_unit.sv */
// top level of the motor play-pattern sequencer
//
// Input beats arrive on the s_ channel: tuser carries the operation (update
// or reset of the behaviour state), tdata the play mode, the millisecond
// timestamp and an external random pick. Each update beat yields exactly one
// motor command beat (direction, duty) on the m_ channel; a reset beat clears
// the cycle start and pattern number and yields nothing.
// A beat is registered in the input register on acceptance and passes through
// the pattern logic into the output register, which drives m_tvalid. One beat
// per cycle is sustained while the receiver does not stall; the elapsed-time
// subtract and compare between the two registers are combinational, and the
// state register is written on the same edge that moves the beat on, so the
// next beat sees it at once.
// When the receiver stalls, the result holds in the output register and one
// further beat waits in the input register before s_tready drops.
// aresetn (synchronous, active low) empties both registers and returns the
// state to not started with pattern zero.
`default_nettype none

module motor_play_pattern_sequencer_unit #(
    parameter int FULL_DUTY = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // play_mode[1:0], now_ms[33:2], random_pick[36:34]
    input  wire logic [0:0]  s_tuser,   // operation[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // direction[1:0], duty[9:2]
);

    logic        in_vld_reg;
    logic        in_op_reg;
    logic [1:0]  in_mode_reg;
    logic [31:0] in_now_reg;
    logic [2:0]  in_pick_reg;

    logic        out_vld_reg;
    logic        out_vld_next;
    msq_pkg::msq_result_t out_res_reg;

    msq_pkg::msq_state_t state_reg;
    msq_pkg::msq_state_t state_next;
    msq_pkg::msq_result_t res_next;
    logic        has_result;
    logic        advance;

    // the held beat moves on when it gives no result or the output slot is free or being read
    assign advance  = in_vld_reg && (!has_result || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser[0];
            in_mode_reg <= s_tdata[1:0];
            in_now_reg  <= s_tdata[33:2];
            in_pick_reg <= s_tdata[36:34];
        end
    end

    msq_tick #(
        .FULL_DUTY (FULL_DUTY)
    ) u_tick (
        .operation   (in_op_reg),
        .play_mode   (in_mode_reg),
        .now_ms      (in_now_reg),
        .random_pick (in_pick_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .result      (res_next),
        .has_result  (has_result)
    );

    // behaviour state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_comb begin
        out_vld_next = out_vld_reg && !m_tready;
        if (advance && has_result) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
        if (advance && has_result) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_res_reg.duty, out_res_reg.direction};

endmodule

`default_nettype wire

/* hw/rtl/msq_checker.sv */
// port-level checks for the motor play-pattern sequencer, bound to the top level
`default_nettype none

module msq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // output slot is empty straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // a fresh result follows an accepted update beat
    a_rise_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready &&
                                  s_tuser[0] == msq_pkg::OP_UPDATE, 2))
        else $error("result beat without an accepted update beat");

    // direction code legal and a stopped motor has zero duty
    a_stop_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3 &&
                     (m_tdata[1:0] != msq_pkg::DIR_STOP || m_tdata[9:2] == 8'd0))
        else $error("bad direction or duty while stopped");

endmodule

bind motor_play_pattern_sequencer_unit msq_checker u_msq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* verif/msq_command_checker.sv */
// checker for the motor play-pattern sequencer: predicts motor commands and compares them
module msq_command_checker #(
    parameter int FULL_DUTY = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // play_mode[1:0], now_ms[33:2], random_pick[36:34]
    input  logic [0:0]  s_tuser,   // operation[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // direction[1:0], duty[9:2]
    output int          fail_count,
    output int          outstanding
);

    // predicted behaviour state
    logic [31:0] cycle_start;
    logic [2:0]  pattern_no;

    msq_pkg::msq_result_t expected_cmds[$];
    msq_pkg::msq_result_t want_cmd;
    msq_pkg::msq_result_t got_cmd;
    int          fails = 0;

    // duty as a percentage of full scale, kept to eight bits
    function automatic logic [7:0] duty_pct(input int unsigned pc);
        return 8'((FULL_DUTY * pc) / 100);
    endfunction

    // start or restart the cycle when due, return the time into it
    function automatic logic [31:0] cycle_elapsed(input logic [31:0] now,
                                                  input logic [31:0] cycle_len,
                                                  input logic [2:0]  pick);
        logic [31:0] el;
        if (cycle_start == '0) begin
            cycle_start = now;
            pattern_no  = pick;
        end
        el = now - cycle_start;
        if (el > cycle_len) begin
            cycle_start = now;
            pattern_no  = pick;
            el          = '0;
        end
        return el;
    endfunction

    // motor command for one update beat, advancing the predicted state
    function automatic msq_pkg::msq_result_t predict_command(input logic [1:0]  mode,
                                                             input logic [31:0] now,
                                                             input logic [2:0]  pick);
        msq_pkg::msq_result_t cmd;
        logic [31:0] el;
        logic        rev;
        logic        burst;
        logic        flip;
        logic [1:0]  run_dir;
        cmd.direction = msq_pkg::DIR_STOP;
        cmd.duty      = 8'd0;
        case (mode)
            msq_pkg::MODE_CALM: begin
                el = cycle_elapsed(now, msq_pkg::CHILL_CYCLE_MS, 3'd0);
                if (el < msq_pkg::CHILL_FWD_END_MS) begin
                    cmd.direction = msq_pkg::DIR_FWD;
                    cmd.duty      = duty_pct(60);
                end else if (el >= msq_pkg::CHILL_REV_BEG_MS &&
                             el < msq_pkg::CHILL_REV_END_MS) begin
                    cmd.direction = msq_pkg::DIR_REV;
                    cmd.duty      = duty_pct(60);
                end
            end
            msq_pkg::MODE_BUILD: begin
                el      = cycle_elapsed(now, msq_pkg::WARMUP_CYCLE_MS, {1'b0, pick[1:0]});
                rev     = pattern_no >= 3'd2;
                burst   = (pattern_no == 3'd1) || (pattern_no == 3'd3);
                run_dir = rev ? msq_pkg::DIR_REV : msq_pkg::DIR_FWD;
                if (el < msq_pkg::WARMUP_RUN_END_MS) begin
                    cmd.direction = run_dir;
                    cmd.duty      = duty_pct(50);
                end else if (el < msq_pkg::WARMUP_BURST_END_MS && burst) begin
                    cmd.direction = run_dir;
                    cmd.duty      = duty_pct(80);
                end
            end
            msq_pkg::MODE_FRENZY: begin
                el      = cycle_elapsed(now, msq_pkg::CRAZY_CYCLE_MS, pick);
                rev     = pattern_no[2];
                run_dir = rev ? msq_pkg::DIR_REV : msq_pkg::DIR_FWD;
                case (pattern_no[1:0])
                    2'd0: begin
                        cmd.direction = run_dir;
                        cmd.duty      = 8'(FULL_DUTY);
                    end
                    2'd1: begin
                        if (el < msq_pkg::CRAZY_SHORT_END_MS) begin
                            cmd.direction = run_dir;
                            cmd.duty      = duty_pct(90);
                        end
                    end
                    2'd2: begin
                        if (el < msq_pkg::CRAZY_LONG_END_MS) begin
                            cmd.direction = run_dir;
                            cmd.duty      = duty_pct(60);
                        end
                    end
                    default: begin
                        // direction toggles every 200 ms
                        flip          = ((el / 32'd200) & 32'd1) != 32'd0;
                        cmd.direction = (rev != flip) ? msq_pkg::DIR_REV : msq_pkg::DIR_FWD;
                        cmd.duty      = 8'(FULL_DUTY);
                    end
                endcase
            end
            default: begin
                cmd.direction = msq_pkg::DIR_STOP;
                cmd.duty      = 8'd0;
            end
        endcase
        return cmd;
    endfunction

    // watch both channels on every edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            cycle_start = '0;
            pattern_no  = '0;
            expected_cmds.delete();
        end else begin
            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                got_cmd.direction = m_tdata[1:0];
                got_cmd.duty      = m_tdata[9:2];
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected command beat, expected none, got dir=%0d duty=%0d",
                             $time, got_cmd.direction, got_cmd.duty);
                    fails++;
                end else begin
                    want_cmd = expected_cmds.pop_front();
                    if (got_cmd.direction !== want_cmd.direction) begin
                        $display("%0t: direction mismatch, expected %0d, got %0d",
                                 $time, want_cmd.direction, got_cmd.direction);
                        fails++;
                    end
                    if (got_cmd.duty !== want_cmd.duty) begin
                        $display("%0t: duty mismatch, expected %0d, got %0d",
                                 $time, want_cmd.duty, got_cmd.duty);
                        fails++;
                    end
                end
            end
            // input beat: clear state or predict a command
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == msq_pkg::OP_RESET) begin
                    cycle_start = '0;
                    pattern_no  = '0;
                end else begin
                    expected_cmds.push_back(predict_command(s_tdata[1:0], s_tdata[33:2],
                                                            s_tdata[36:34]));
                end
            end
        end
        fail_count  <= fails;
        outstanding <= expected_cmds.size();
    end

endmodule

/* verif/motor_play_pattern_sequencer_unit_tb.sv */
// testbench top for the motor play-pattern sequencer: stimulus, receiver stalls and verdict
module motor_play_pattern_sequencer_unit_tb;

    localparam int N_ITEMS = 1150;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // play_mode[1:0], now_ms[33:2], random_pick[36:34]
    logic [0:0]  s_tuser;    // operation[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // direction[1:0], duty[9:2]

    int fail_count;
    int outstanding;
    int burst_left = 0;
    int sent = 0;

    // clock
    always begin
        #5;
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
    end

    motor_play_pattern_sequencer_unit #(
        .FULL_DUTY(255)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    msq_command_checker #(
        .FULL_DUTY(255)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // offer one beat, in bursts with random gaps between them
    task automatic offer(input logic op, input logic [1:0] mode, input logic [31:0] now,
                         input logic [2:0] pick);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {3'b000, pick, now, mode};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // receiver stall pattern, with one long hold-off to back the block up
    initial begin : rx_pattern
        int  cyc;
        int  style;
        int  len;
        bit  held;
        cyc  = 0;
        held = 0;
        m_tready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            style = $urandom_range(0, 3);
            len   = $urandom_range(20, 200);
            repeat (len) begin
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= cyc[0];
                endcase
                @(posedge aclk);
                cyc++;
            end
            if (!held && cyc > 800) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [31:0] t;
        logic [31:0] b;
        logic [1:0]  mode;
        int          roll;
        int          run_len;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= msq_pkg::OP_UPDATE;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // chill: start at time zero, restart, every phase, cycle boundary
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_CALM, 32'd0, 3'd7);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_CALM, 32'd1, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_CALM, 32'd2001, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_CALM, 32'd3001, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_CALM, 32'd5001, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_CALM, 32'd8001, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_CALM, 32'd8002, 3'd0);
        offer(msq_pkg::OP_RESET, msq_pkg::MODE_FRENZY, 32'hFFFF_FFFF, 3'd7);

        // warmup across the timestamp wrap, burst and cycle boundary
        b = 32'hFFFF_FF00;
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_BUILD, b, 3'd7);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_BUILD, b + 32'd1600, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_BUILD, b + 32'd3000, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_BUILD, b + 32'd3001, 3'd1);

        // crazy taking over the warmup pattern, then toggling
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_FRENZY, b + 32'd4000, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_FRENZY, b + 32'd4002, 3'd7);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_FRENZY, b + 32'd4202, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_FRENZY, b + 32'd4402, 3'd4);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_STOP, b + 32'd4500, 3'd3);
        offer(msq_pkg::OP_RESET, msq_pkg::MODE_CALM, 32'd0, 3'd0);

        // crazy reverse patterns and a toggling one, then other modes over its pattern
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_FRENZY, 32'd12345, 3'd4);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_FRENZY, 32'd13346, 3'd5);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_FRENZY, 32'd14347, 3'd6);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_FRENZY, 32'd15348, 3'd3);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_CALM, 32'd15448, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_BUILD, 32'd15548, 3'd0);
        offer(msq_pkg::OP_UPDATE, msq_pkg::MODE_STOP, 32'd0, 3'd0);

        // random part: mostly timed runs in one mode, some noise and state resets
        while (sent < N_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                offer(msq_pkg::OP_RESET, 2'($urandom), $urandom, 3'($urandom));
            end else if (roll < 10) begin
                offer(msq_pkg::OP_UPDATE, 2'($urandom), $urandom, 3'($urandom));
            end else begin
                mode = ($urandom_range(0, 9) == 0) ? msq_pkg::MODE_STOP
                                                   : 2'($urandom_range(0, 2));
                case ($urandom_range(0, 3))
                    0:       t = 32'd0;
                    1:       t = 32'hFFFF_FFFF - $urandom_range(0, 9000);
                    default: t = $urandom;
                endcase
                run_len = $urandom_range(8, 40);
                repeat (run_len) begin
                    // now and then another mode takes over mid-run
                    if ($urandom_range(0, 19) == 0)
                        mode = 2'($urandom);
                    offer(msq_pkg::OP_UPDATE, mode, t, 3'($urandom));
                    case (mode)
                        msq_pkg::MODE_CALM:  t = t + $urandom_range(0, 1200);
                        msq_pkg::MODE_BUILD: t = t + $urandom_range(0, 450);
                        default:             t = t + $urandom_range(0, 150);
                    endcase
                end
            end
        end

        // drain and settle
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("motor_play_pattern_sequencer_unit_tb: PASS");
        end else begin
            $display("motor_play_pattern_sequencer_unit_tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("motor_play_pattern_sequencer_unit_tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/msq_pkg.sv
hw/rtl/msq_tick.sv
hw/rtl/motor_play_pattern_sequencer_unit.sv
hw/rtl/msq_checker.sv
verif/msq_command_checker.sv
verif/motor_play_pattern_sequencer_unit_tb.sv
